FILE: design/kbt_pkg.sv
// Shared types, constants and check functions for the keyboard report key tracker.
package kbt_pkg;

    localparam int SLOT_COUNT   = 6;
    localparam int REPORT_CODES = 6;
    localparam int OUT_SLOTS    = 6;
    localparam int CODE_W       = 8;
    localparam int STATE_W      = 2;
    localparam int CNT_W        = $clog2(((SLOT_COUNT > REPORT_CODES) ?
                                          SLOT_COUNT : REPORT_CODES) + 1);
    localparam int IN_TDATA_W   = REPORT_CODES * CODE_W;
    localparam int OUT_BITS     = OUT_SLOTS * (CODE_W + STATE_W);
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [STATE_W-1:0] slot_state_t;

    localparam slot_state_t ST_NONE     = 2'd0;
    localparam slot_state_t ST_PRESSED  = 2'd1;
    localparam slot_state_t ST_RELEASED = 2'd2;
    localparam slot_state_t ST_HELD     = 2'd3;

    typedef enum logic {
        CMD_REPORT    = 1'b0,
        CMD_FRAME_END = 1'b1
    } cmd_t;

    typedef struct packed {
        cmd_t                         command;
        code_t [REPORT_CODES-1:0]     codes;
    } item_t;

    typedef struct packed {
        code_t       [SLOT_COUNT-1:0] codes;
        slot_state_t [SLOT_COUNT-1:0] states;
    } slots_t;

    // An empty slot has code zero and state none, and only then.
    function automatic logic slots_consistent(input slots_t sl);
        logic ok;
        ok = 1'b1;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            if ((sl.codes[s] == '0) != (sl.states[s] == ST_NONE)) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    // No keycode is held in two occupied slots.
    function automatic logic slots_unique(input slots_t sl);
        logic ok;
        ok = 1'b1;
        for (int a = 0; a < SLOT_COUNT; a++) begin
            for (int b = a + 1; b < SLOT_COUNT; b++) begin
                if (sl.codes[a] != '0 && sl.codes[a] == sl.codes[b]) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

endpackage

FILE: design/kbt_in_reg.sv
// Input register stage that holds one accepted word until the update logic takes it.
module kbt_in_reg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [kbt_pkg::IN_TDATA_W-1:0]      s_tdata,  // code_0 .. code_5, 8 bits each
    input  logic                                s_tuser,  // command
    input  logic                                drain,
    output logic                                item_valid,
    output kbt_pkg::item_t                      item
);

    logic           valid_reg;
    logic           valid_next;
    kbt_pkg::item_t item_reg;
    logic           accept;

    assign s_tready   = !valid_reg || drain;
    assign accept     = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (drain) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.command <= kbt_pkg::cmd_t'(s_tuser);
            item_reg.codes   <= s_tdata;
        end
    end

endmodule

FILE: design/kbt_slot_update.sv
// Next-state logic for the key slots: free, release and claim for a report, aging at frame end.
module kbt_slot_update (
    input  kbt_pkg::item_t  item,
    input  kbt_pkg::slots_t cur,
    output kbt_pkg::slots_t nxt
);

    localparam int SC = kbt_pkg::SLOT_COUNT;
    localparam int RC = kbt_pkg::REPORT_CODES;
    localparam int CW = kbt_pkg::CNT_W;

    kbt_pkg::code_t     free_code [SC];
    logic               in_rep    [SC];
    logic [CW-1:0]      erank     [SC];
    logic               nz        [RC];
    logic               match_ex  [RC];
    logic               dup       [RC];
    logic               later_dup [RC];
    logic               newf      [RC];
    logic [CW-1:0]      rank      [RC];

    // Slots left released by the previous report are freed first.
    always_comb begin
        for (int s = 0; s < SC; s++) begin
            free_code[s] = (cur.states[s] == kbt_pkg::ST_RELEASED) ? '0 : cur.codes[s];
        end
    end

    always_comb begin
        for (int i = 0; i < RC; i++) begin
            nz[i]        = item.codes[i] != '0;
            match_ex[i]  = 1'b0;
            dup[i]       = 1'b0;
            later_dup[i] = 1'b0;
            for (int s = 0; s < SC; s++) begin
                if (free_code[s] == item.codes[i]) begin
                    match_ex[i] = 1'b1;
                end
            end
            for (int j = 0; j < RC; j++) begin
                if (item.codes[j] == item.codes[i]) begin
                    if (j < i) begin
                        dup[i] = 1'b1;
                    end
                    if (j > i) begin
                        later_dup[i] = 1'b1;
                    end
                end
            end
            newf[i] = nz[i] && !match_ex[i] && !dup[i];
        end
    end

    // New codes are numbered in report order; empty slots are numbered from slot 0 up.
    always_comb begin
        rank[0] = '0;
        for (int i = 1; i < RC; i++) begin
            rank[i] = rank[i-1] + CW'(newf[i-1]);
        end
        erank[0] = '0;
        for (int s = 1; s < SC; s++) begin
            erank[s] = erank[s-1] + CW'(free_code[s-1] == '0);
        end
    end

    always_comb begin
        for (int s = 0; s < SC; s++) begin
            in_rep[s] = 1'b0;
            for (int i = 0; i < RC; i++) begin
                if (nz[i] && item.codes[i] == free_code[s]) begin
                    in_rep[s] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        nxt = cur;
        if (item.command == kbt_pkg::CMD_FRAME_END) begin
            for (int s = 0; s < SC; s++) begin
                if (cur.states[s] == kbt_pkg::ST_PRESSED) begin
                    nxt.states[s] = kbt_pkg::ST_HELD;
                end
            end
        end else begin
            for (int s = 0; s < SC; s++) begin
                nxt.codes[s] = free_code[s];
                if (free_code[s] != '0) begin
                    nxt.states[s] = in_rep[s] ? kbt_pkg::ST_HELD : kbt_pkg::ST_RELEASED;
                end else begin
                    nxt.states[s] = kbt_pkg::ST_NONE;
                    for (int i = 0; i < RC; i++) begin
                        if (newf[i] && rank[i] == erank[s]) begin
                            nxt.codes[s]  = item.codes[i];
                            nxt.states[s] = later_dup[i] ? kbt_pkg::ST_HELD
                                                         : kbt_pkg::ST_PRESSED;
                        end
                    end
                end
            end
        end
    end

endmodule

FILE: design/keyboard_report_key_tracker_top.sv
// Top level of the keyboard report key tracker: slot register, result channel and checks.
//
// The s_ channel takes one word per boot-keyboard report or frame-end marker.
// s_tuser carries the command (0 report, 1 frame end) and s_tdata the six report
// keycodes, code_0 in the lowest byte. Every accepted word yields exactly one
// result word on the m_ channel: a snapshot of all six slots after the update,
// slot keycodes in the low 48 bits and 2-bit slot states above them.
// A word accepted on the s_ channel lands in the input register, and its result
// is registered in the slot register and presented on m_tvalid.
// One word is accepted per cycle while m_tready does not stall the result;
// the slot update is combinational logic between the input and slot registers.
// The slot register doubles as the result register, so a stalled m_tready holds
// the result steady, and the input register then holds one more word before
// s_tready drops. Reset clears both valid flags and empties every slot.
module keyboard_report_key_tracker_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [kbt_pkg::IN_TDATA_W-1:0]      s_tdata,  // code_0 .. code_5, 8 bits each
    input  logic                                s_tuser,  // command
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [kbt_pkg::OUT_TDATA_W-1:0]     m_tdata   // slot_key_0 .. slot_key_5,
                                                          // slot_state_0 .. slot_state_5
);

    localparam int SC   = kbt_pkg::SLOT_COUNT;
    localparam int OS   = kbt_pkg::OUT_SLOTS;
    localparam int CDW  = kbt_pkg::CODE_W;
    localparam int STW  = kbt_pkg::STATE_W;

    logic            drain;
    logic            item_valid;
    kbt_pkg::item_t  item;
    logic            take;
    kbt_pkg::slots_t slots_reg;
    kbt_pkg::slots_t slots_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    assign drain = !out_valid_reg || m_tready;
    assign take  = item_valid && drain;

    kbt_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .drain      (drain),
        .item_valid (item_valid),
        .item       (item)
    );

    kbt_slot_update u_slot_update (
        .item (item),
        .cur  (slots_reg),
        .nxt  (slots_next)
    );

    always_comb begin
        if (take) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            slots_reg     <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                slots_reg <= slots_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;

    always_comb begin
        m_tdata = '0;
        for (int s = 0; s < OS; s++) begin
            if (s < SC) begin
                m_tdata[s*CDW +: CDW]           = slots_reg.codes[s];
                m_tdata[OS*CDW + s*STW +: STW]  = slots_reg.states[s];
            end
        end
    end

`ifndef SYNTHESIS
    a_slots_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        kbt_pkg::slots_consistent(slots_reg))
        else $error("slot code and slot state disagree on emptiness");

    a_slots_unique: assert property (@(posedge aclk) disable iff (!aresetn)
        kbt_pkg::slots_unique(slots_reg))
        else $error("one keycode occupies two slots");

    a_frame_end_keeps_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        take && item.command == kbt_pkg::CMD_FRAME_END |=> $stable(slots_reg.codes))
        else $error("frame end changed slot keycodes");

    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no result pending");
`endif

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the keyboard report key tracker, with a slot predictor.
module tb;

    localparam int RANDOM_WORDS = 1830;
    localparam int QUIET_LIMIT  = 600;

    typedef struct packed {
        logic                                      may_idle;
        kbt_pkg::cmd_t                             command;
        kbt_pkg::code_t [kbt_pkg::REPORT_CODES-1:0] codes;
    } word_t;

    typedef struct packed {
        kbt_pkg::code_t       [kbt_pkg::OUT_SLOTS-1:0] keys;
        kbt_pkg::slot_state_t [kbt_pkg::OUT_SLOTS-1:0] states;
    } snapshot_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [kbt_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                            s_tuser  = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [kbt_pkg::OUT_TDATA_W-1:0] m_tdata;

    word_t                pending_words[$];
    snapshot_t            due_snapshots[$];
    kbt_pkg::code_t       held_code [kbt_pkg::SLOT_COUNT];
    kbt_pkg::slot_state_t held_state[kbt_pkg::SLOT_COUNT];
    word_t                on_bus;
    logic                 sink_stalls = 1'b0;
    int                   send_gap    = 0;
    int                   sink_gap    = 0;
    int                   quiet       = 0;
    int                   mismatches  = 0;
    int                   reports     = 0;
    int                   frame_ends  = 0;
    int                   checked     = 0;

    keyboard_report_key_tracker_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        for (int s = 0; s < kbt_pkg::SLOT_COUNT; s++) begin
            held_code[s]  = '0;
            held_state[s] = kbt_pkg::ST_NONE;
        end
    end

    // Apply one accepted word to the slot copy and record the snapshot it must produce.
    task automatic track_word(input word_t w);
        snapshot_t      snap;
        logic           listed;
        logic           hit;
        logic           placed;
        kbt_pkg::code_t c;
        if (w.command == kbt_pkg::CMD_FRAME_END) begin
            frame_ends++;
            for (int s = 0; s < kbt_pkg::SLOT_COUNT; s++) begin
                if (held_state[s] == kbt_pkg::ST_PRESSED) begin
                    held_state[s] = kbt_pkg::ST_HELD;
                end
            end
        end else begin
            reports++;
            for (int s = 0; s < kbt_pkg::SLOT_COUNT; s++) begin
                if (held_state[s] == kbt_pkg::ST_RELEASED) begin
                    held_state[s] = kbt_pkg::ST_NONE;
                    held_code[s]  = '0;
                end
            end
            for (int s = 0; s < kbt_pkg::SLOT_COUNT; s++) begin
                if (held_code[s] != '0) begin
                    listed = 1'b0;
                    for (int i = 0; i < kbt_pkg::REPORT_CODES; i++) begin
                        if (w.codes[i] != '0 && w.codes[i] == held_code[s]) begin
                            listed = 1'b1;
                        end
                    end
                    if (!listed) begin
                        held_state[s] = kbt_pkg::ST_RELEASED;
                    end
                end
            end
            for (int i = 0; i < kbt_pkg::REPORT_CODES; i++) begin
                c = w.codes[i];
                if (c != '0) begin
                    hit = 1'b0;
                    for (int s = 0; s < kbt_pkg::SLOT_COUNT; s++) begin
                        if (held_code[s] == c) begin
                            held_state[s] = kbt_pkg::ST_HELD;
                            hit = 1'b1;
                        end
                    end
                    placed = hit;
                    for (int s = 0; s < kbt_pkg::SLOT_COUNT; s++) begin
                        if (!placed && held_code[s] == '0) begin
                            held_code[s]  = c;
                            held_state[s] = kbt_pkg::ST_PRESSED;
                            placed = 1'b1;
                        end
                    end
                end
            end
        end
        for (int s = 0; s < kbt_pkg::OUT_SLOTS; s++) begin
            snap.keys[s]   = (s < kbt_pkg::SLOT_COUNT) ? held_code[s] : kbt_pkg::code_t'(0);
            snap.states[s] = (s < kbt_pkg::SLOT_COUNT) ? held_state[s] : kbt_pkg::ST_NONE;
        end
        due_snapshots.push_back(snap);
    endtask

    task automatic check_word(input logic [kbt_pkg::OUT_TDATA_W-1:0] data);
        snapshot_t            want;
        kbt_pkg::code_t       got_key;
        kbt_pkg::slot_state_t got_state;
        if (due_snapshots.size() == 0) begin
            $error("result word with no expectation waiting: m_tdata %h", data);
            mismatches++;
        end else begin
            want = due_snapshots.pop_front();
            checked++;
            for (int s = 0; s < kbt_pkg::OUT_SLOTS; s++) begin
                got_key   = data[kbt_pkg::CODE_W*s +: kbt_pkg::CODE_W];
                got_state = data[kbt_pkg::OUT_SLOTS*kbt_pkg::CODE_W + kbt_pkg::STATE_W*s
                                 +: kbt_pkg::STATE_W];
                if (got_key !== want.keys[s]) begin
                    $error("slot_key_%0d: expected %0d, actual %0d", s, want.keys[s], got_key);
                    mismatches++;
                end
                if (got_state !== want.states[s]) begin
                    $error("slot_state_%0d: expected %0d, actual %0d",
                           s, want.states[s], got_state);
                    mismatches++;
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                track_word(on_bus);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    on_bus = pending_words.pop_front();
                    sink_stalls = on_bus.may_idle;
                    s_tvalid <= 1'b1;
                    s_tdata  <= on_bus.codes;
                    s_tuser  <= on_bus.command;
                    if (on_bus.may_idle && $urandom_range(0, 11) == 0) begin
                        send_gap = $urandom_range(1, 13);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_word(m_tdata);
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (sink_stalls && $urandom_range(0, 11) == 0) begin
                    sink_gap = $urandom_range(1, 13);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task automatic add_word(input kbt_pkg::cmd_t cmd,
                            input kbt_pkg::code_t [kbt_pkg::REPORT_CODES-1:0] codes,
                            input logic may_idle);
        word_t w;
        w.may_idle = may_idle;
        w.command  = cmd;
        w.codes    = codes;
        pending_words.push_back(w);
    endtask

    task automatic add_report(input kbt_pkg::code_t c0, input kbt_pkg::code_t c1,
                              input kbt_pkg::code_t c2, input kbt_pkg::code_t c3,
                              input kbt_pkg::code_t c4, input kbt_pkg::code_t c5);
        add_word(kbt_pkg::CMD_REPORT, {c5, c4, c3, c2, c1, c0}, 1'b1);
    endtask

    task automatic add_random_part();
        kbt_pkg::code_t                             down[$];
        kbt_pkg::code_t [kbt_pkg::REPORT_CODES-1:0] rc;
        logic                                       may_idle;
        int                                         roll;
        int                                         pos;
        may_idle = 1'b1;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 150 == 0) begin
                may_idle = (n < RANDOM_WORDS - 250) && ($urandom_range(0, 2) != 0);
            end
            for (int i = 0; i < kbt_pkg::REPORT_CODES; i++) begin
                rc[i] = ($urandom_range(0, 3) == 0) ? kbt_pkg::code_t'(0)
                                                    : kbt_pkg::code_t'($urandom_range(0, 255));
            end
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                add_word(($urandom_range(0, 1) == 1) ? kbt_pkg::CMD_FRAME_END
                                                     : kbt_pkg::CMD_REPORT, rc, may_idle);
            end else if (roll < 32) begin
                add_word(kbt_pkg::CMD_FRAME_END, rc, may_idle);
            end else begin
                roll = $urandom_range(0, 19);
                if (roll < 8 && down.size() < kbt_pkg::REPORT_CODES) begin
                    down.push_back(kbt_pkg::code_t'($urandom_range(1, 255)));
                end else if (roll < 14 && down.size() > 0) begin
                    down.delete($urandom_range(0, down.size() - 1));
                end else if (roll == 14) begin
                    down.delete();
                end
                rc = '0;
                foreach (down[k]) begin
                    do begin
                        pos = $urandom_range(0, kbt_pkg::REPORT_CODES - 1);
                    end while (rc[pos] != '0);
                    rc[pos] = down[k];
                end
                if (down.size() > 0 && down.size() < kbt_pkg::REPORT_CODES
                        && $urandom_range(0, 7) == 0) begin
                    do begin
                        pos = $urandom_range(0, kbt_pkg::REPORT_CODES - 1);
                    end while (rc[pos] != '0);
                    rc[pos] = down[$urandom_range(0, down.size() - 1)];
                end
                add_word(kbt_pkg::CMD_REPORT, rc, may_idle);
            end
        end
    endtask

    initial begin
        add_word(kbt_pkg::CMD_FRAME_END, {kbt_pkg::REPORT_CODES{8'hFF}}, 1'b1);
        add_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_report(8'h01, 8'h02, 8'h04, 8'h80, 8'hFF, 8'h7F);
        add_word(kbt_pkg::CMD_FRAME_END, '0, 1'b1);
        add_report(8'hFF, 8'h7F, 8'h80, 8'h04, 8'h02, 8'h01);
        add_report(8'h01, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00);
        add_report(8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15);
        add_report(8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25);
        add_report(8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35);
        add_report(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h00, 8'h33);
        add_word(kbt_pkg::CMD_FRAME_END, '0, 1'b1);
        add_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFE);
        add_report(8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_report(8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_report(8'h41, 8'h41, 8'h41, 8'h41, 8'h41, 8'h41);
        add_word(kbt_pkg::CMD_FRAME_END, {kbt_pkg::REPORT_CODES{8'h5A}}, 1'b1);
        add_report(8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46);
        add_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        add_random_part();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_words.size() != 0 || s_tvalid || due_snapshots.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
        if (due_snapshots.size() != 0) begin
            $error("%0d expected result words never arrived", due_snapshots.size());
            mismatches++;
        end

        $display("Drove %0d keyboard reports and %0d frame-end words,", reports, frame_ends);
        $display("and compared %0d slot snapshots field by field.", checked);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: files.f
design/kbt_pkg.sv
design/kbt_in_reg.sv
design/kbt_slot_update.sv
design/keyboard_report_key_tracker_top.sv
verif/tb.sv
